// ----- sv/pit_pkg.sv -----
package pit_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IRQ_BITS = 4;

  localparam int ADDR_W = 14;
  localparam int DATA_W = 32;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_MCTRL     = 14'h000;
  localparam logic [ADDR_W-1:0] ADDR_CHAN_BASE = 14'h100;

  // register slot within a 16-byte channel window
  localparam logic [1:0] SLOT_LOAD  = 2'd0;
  localparam logic [1:0] SLOT_COUNT = 2'd1;
  localparam logic [1:0] SLOT_CTRL  = 2'd2;
  localparam logic [1:0] SLOT_FLAG  = 2'd3;

  // control word bits
  localparam int MCTRL_DIS_BIT = 1;
  localparam int CCTRL_EN_BIT  = 0;
  localparam int CCTRL_IE_BIT  = 1;

  typedef struct packed {
    logic            is_mctrl;
    logic            is_chan;
    logic [CH_W-1:0] ch;
    logic [1:0]      slot;
  } dec_t;

  typedef struct packed {
    logic load_we;
    logic ctrl_we;
    logic flag_we;
    logic tick;
  } chan_cmd_t;

endpackage

// ----- sv/pit_decode.sv -----
module pit_decode
  import pit_pkg::*;
(
  input  logic [ADDR_W-1:0] addr,
  output dec_t              dec
);

  logic [ADDR_W-1:0] rel;
  logic              in_range;

  assign rel = addr - ADDR_CHAN_BASE;

  always_comb begin
    in_range     = (addr >= ADDR_CHAN_BASE) && (rel[1:0] == 2'b00) &&
                   ({4'd0, rel[ADDR_W-1:4]} < ADDR_W'(CHANNELS));
    dec.is_mctrl = (addr == ADDR_MCTRL);
    dec.is_chan  = in_range;
    dec.ch       = rel[CH_W+3:4];
    dec.slot     = rel[3:2];
  end

endmodule

// ----- sv/pit_chan.sv -----
module pit_chan
  import pit_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  chan_cmd_t         ccmd,
  input  logic [DATA_W-1:0] wdata,
  input  logic [1:0]        slot,
  output logic [DATA_W-1:0] rd,
  output logic              irq_next
);

  logic [DATA_W-1:0] load_value, load_value_next;
  logic [DATA_W-1:0] live_count, live_count_next;
  logic [1:0]        chan_ctrl, chan_ctrl_next;
  logic              chan_flag, chan_flag_next;

  always_comb begin
    load_value_next = load_value;
    live_count_next = live_count;
    chan_ctrl_next  = chan_ctrl;
    chan_flag_next  = chan_flag;
    if (ccmd.load_we) begin
      load_value_next = wdata;
      live_count_next = wdata;
    end
    if (ccmd.ctrl_we) begin
      chan_ctrl_next = wdata[1:0];
    end
    if (ccmd.flag_we && wdata[0]) begin
      chan_flag_next = 1'b0;
    end
    if (ccmd.tick && chan_ctrl[CCTRL_EN_BIT]) begin
      if (live_count <= DATA_W'(1)) begin
        chan_flag_next  = 1'b1;
        live_count_next = load_value;
      end else begin
        live_count_next = live_count - DATA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_value <= '0;
      live_count <= '0;
      chan_ctrl  <= '0;
      chan_flag  <= 1'b0;
    end else begin
      load_value <= load_value_next;
      live_count <= live_count_next;
      chan_ctrl  <= chan_ctrl_next;
      chan_flag  <= chan_flag_next;
    end
  end

  always_comb begin
    unique case (slot)
      SLOT_LOAD:  rd = load_value;
      SLOT_COUNT: rd = live_count;
      SLOT_CTRL:  rd = {{(DATA_W-2){1'b0}}, chan_ctrl};
      SLOT_FLAG:  rd = {{(DATA_W-1){1'b0}}, chan_flag};
      default:    rd = '0;
    endcase
  end

  assign irq_next = chan_flag_next & chan_ctrl_next[CCTRL_IE_BIT];

endmodule

// ----- sv/periodic_interrupt_timer_4ch.sv -----
// Four-channel periodic interrupt timer. Each item is a bus read, a bus
// write or one count tick, and each item gives exactly one result: rdata
// (read data, zero otherwise) and irq_lines (flag AND interrupt enable of
// channels 0..3 after the item). Items pass an input register and then a
// result register, with the register update done in between; one item is
// taken every cycle unless a stalled output holds the pipeline. Channel
// regs sit at 0x100+16*ch:
// +0 load (also loads the count), +4 count (read only), +8 ctrl
// (bit0 enable, bit1 irq enable), +0xC flag (write 1 to clear). Offset 0
// is the module control word; its bit 1 stops all channels, bit 0 is
// stored only.
module periodic_interrupt_timer_4ch
  import pit_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [DATA_W-1:0]   wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   rdata,
  output logic [IRQ_BITS-1:0] irq_lines
);

  logic              s1_valid;
  logic [1:0]        s1_cmd;
  logic [ADDR_W-1:0] s1_addr;
  logic [DATA_W-1:0] s1_wdata;
  logic              advance;
  logic              fire;

  logic [1:0]        module_ctrl, module_ctrl_next;
  dec_t              dec;
  logic [DATA_W-1:0] chan_rd [CHANNELS];
  logic [CHANNELS-1:0] chan_irq;
  logic [DATA_W-1:0] rdata_next;
  logic [IRQ_BITS-1:0] irq_next;
  logic              is_read;
  logic              is_write;
  logic              tick_en;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd   <= cmd;
      s1_addr  <= addr;
      s1_wdata <= wdata;
    end
  end

  pit_decode u_decode (
    .addr (s1_addr),
    .dec  (dec)
  );

  assign is_read  = fire && (s1_cmd == CMD_READ);
  assign is_write = fire && (s1_cmd == CMD_WRITE);
  assign tick_en  = fire && (s1_cmd == CMD_TICK) && !module_ctrl[MCTRL_DIS_BIT];

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    chan_cmd_t ccmd;
    logic      sel;

    assign sel          = is_write && dec.is_chan && (dec.ch == CH_W'(i));
    assign ccmd.load_we = sel && (dec.slot == SLOT_LOAD);
    assign ccmd.ctrl_we = sel && (dec.slot == SLOT_CTRL);
    assign ccmd.flag_we = sel && (dec.slot == SLOT_FLAG);
    assign ccmd.tick    = tick_en;

    pit_chan u_chan (
      .clk      (clk),
      .rst      (rst),
      .ccmd     (ccmd),
      .wdata    (s1_wdata),
      .slot     (dec.slot),
      .rd       (chan_rd[i]),
      .irq_next (chan_irq[i])
    );
  end

  for (genvar j = 0; j < IRQ_BITS; j++) begin : g_irq
    if (j < CHANNELS) begin : g_on
      assign irq_next[j] = chan_irq[j];
    end else begin : g_off
      assign irq_next[j] = 1'b0;
    end
  end

  always_comb begin
    module_ctrl_next = module_ctrl;
    if (is_write && dec.is_mctrl) begin
      module_ctrl_next = s1_wdata[1:0];
    end
  end

  always_comb begin
    rdata_next = '0;
    if (s1_cmd == CMD_READ) begin
      if (dec.is_mctrl) begin
        rdata_next = {{(DATA_W-2){1'b0}}, module_ctrl};
      end else if (dec.is_chan) begin
        rdata_next = chan_rd[dec.ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      module_ctrl <= '0;
      out_valid   <= 1'b0;
    end else begin
      module_ctrl <= module_ctrl_next;
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rdata     <= is_read ? rdata_next : '0;
      irq_lines <= irq_next;
    end
  end

endmodule

// ----- sim/tb_periodic_interrupt_timer_4ch.sv -----
module tb_periodic_interrupt_timer_4ch;
  import pit_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;   // unused command, must be a no-op
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES  = 100;
  localparam int STALL_LIMIT  = 1000;

  // register address of a slot inside a channel window
  function automatic logic [ADDR_W-1:0] chan_addr(int ch, logic [1:0] slot);
    return ADDR_CHAN_BASE + ADDR_W'(16 * ch + 4 * slot);
  endfunction

  class timer_scoreboard;
    typedef struct {
      logic [DATA_W-1:0]   rdata;
      logic [IRQ_BITS-1:0] irq;
    } timer_result_t;

    bit [1:0]        mod_ctrl;
    bit [DATA_W-1:0] reload[CHANNELS];
    bit [DATA_W-1:0] count[CHANNELS];
    bit [1:0]        ch_ctrl[CHANNELS];
    bit              flag[CHANNELS];
    timer_result_t   pending[$];
    int              mismatches;

    function new();
      mod_ctrl = '0;
      mismatches = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        reload[i] = '0;
        count[i] = '0;
        ch_ctrl[i] = '0;
        flag[i] = 1'b0;
      end
    endfunction

    function bit decode_reg(logic [ADDR_W-1:0] a, output int ch, output logic [1:0] slot);
      logic [ADDR_W-1:0] rel;
      ch = 0;
      slot = SLOT_LOAD;
      if (a < ADDR_CHAN_BASE) return 1'b0;
      rel = a - ADDR_CHAN_BASE;
      if (rel[1:0] != 2'b00) return 1'b0;
      if (int'(rel >> 4) >= CHANNELS) return 1'b0;
      ch = int'(rel >> 4);
      slot = rel[3:2];
      return 1'b1;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    // advance the timer state by one accepted item and queue its result
    function void note_item(logic [1:0] c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
      timer_result_t r;
      int ch;
      logic [1:0] slot;
      bit hit;
      r.rdata = '0;
      r.irq = '0;
      hit = decode_reg(a, ch, slot);
      case (c)
        CMD_READ: begin
          if (a == ADDR_MCTRL) r.rdata = DATA_W'(mod_ctrl);
          else if (hit) begin
            case (slot)
              SLOT_LOAD:  r.rdata = reload[ch];
              SLOT_COUNT: r.rdata = count[ch];
              SLOT_CTRL:  r.rdata = DATA_W'(ch_ctrl[ch]);
              SLOT_FLAG:  r.rdata = DATA_W'(flag[ch]);
            endcase
          end
        end
        CMD_WRITE: begin
          if (a == ADDR_MCTRL) mod_ctrl = d[1:0];
          else if (hit) begin
            case (slot)
              SLOT_LOAD: begin
                reload[ch] = d;
                count[ch] = d;
              end
              SLOT_CTRL: ch_ctrl[ch] = d[1:0];
              SLOT_FLAG: if (d[0]) flag[ch] = 1'b0;
              default: ;  // live count is read only
            endcase
          end
        end
        CMD_TICK: begin
          if (!mod_ctrl[MCTRL_DIS_BIT]) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (ch_ctrl[i][CCTRL_EN_BIT]) begin
                if (count[i] <= 1) begin
                  flag[i] = 1'b1;
                  count[i] = reload[i];
                end else begin
                  count[i] = count[i] - 1;
                end
              end
            end
          end
        end
        default: ;
      endcase
      for (int i = 0; i < CHANNELS && i < IRQ_BITS; i++)
        r.irq[i] = flag[i] & ch_ctrl[i][CCTRL_IE_BIT];
      pending.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic [DATA_W-1:0] rd, logic [IRQ_BITS-1:0] irq);
      timer_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result rdata=%h irq_lines=%h", rd, irq));
        return;
      end
      e = pending.pop_front();
      if (rd !== e.rdata)
        report($sformatf("rdata got %h want %h", rd, e.rdata));
      if (irq !== e.irq)
        report($sformatf("irq_lines got %h want %h", irq, e.irq));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd = CMD_READ;
  logic [ADDR_W-1:0]   addr = '0;
  logic [DATA_W-1:0]   wdata = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DATA_W-1:0]   rdata;
  logic [IRQ_BITS-1:0] irq_lines;

  timer_scoreboard sb = new();
  int items_sent = 0;
  int hold_requests = 0;
  int stall_cycles = 0;

  always #2 clk = ~clk;

  periodic_interrupt_timer_4ch dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .addr      (addr),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (rdata),
    .irq_lines (irq_lines)
  );

  // called at a rising edge; leaves valid high after acceptance
  task send_item(logic [1:0] c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    bit taken;
    in_valid <= 1'b1;
    cmd <= c;
    addr <= a;
    wdata <= d;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sb.note_item(c, a, d);
    items_sent++;
  endtask

  task idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  task send_random_access();
    int p;
    int ch;
    int s;
    logic [DATA_W-1:0] d;
    p = $urandom_range(0, 99);
    ch = $urandom_range(0, CHANNELS - 1);
    d = $urandom;
    if (p < 40) begin
      send_item(CMD_TICK, chan_addr(ch, SLOT_LOAD), d);
    end else if (p < 60) begin
      if ($urandom_range(0, 9) == 0) send_item(CMD_READ, ADDR_MCTRL, d);
      else send_item(CMD_READ, chan_addr(ch, 2'($urandom_range(0, 3))), d);
    end else if (p < 88) begin
      s = $urandom_range(0, 99);
      if (s < 30) begin
        // short periods so channels wrap often
        if ($urandom_range(0, 7) != 0) d = $urandom_range(0, 12);
        send_item(CMD_WRITE, chan_addr(ch, SLOT_LOAD), d);
      end else if (s < 60) begin
        if ($urandom_range(0, 2) != 0) d[CCTRL_EN_BIT] = 1'b1;
        send_item(CMD_WRITE, chan_addr(ch, SLOT_CTRL), d);
      end else if (s < 85) begin
        send_item(CMD_WRITE, chan_addr(ch, SLOT_FLAG), d);
      end else if (s < 95) begin
        send_item(CMD_WRITE, chan_addr(ch, SLOT_COUNT), d);
      end else begin
        if ($urandom_range(0, 2) != 0) d[MCTRL_DIS_BIT] = 1'b0;
        send_item(CMD_WRITE, ADDR_MCTRL, d);
      end
    end else begin
      send_item(2'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1)), d);
    end
  endtask

  task run_directed();
    send_item(CMD_READ, ADDR_MCTRL, '0);
    send_item(CMD_READ, chan_addr(0, SLOT_COUNT), '0);
    send_item(CMD_WRITE, chan_addr(0, SLOT_LOAD), '1);
    send_item(CMD_READ, chan_addr(0, SLOT_LOAD), '0);
    send_item(CMD_WRITE, chan_addr(1, SLOT_LOAD), '0);   // fires on every tick
    send_item(CMD_WRITE, chan_addr(2, SLOT_LOAD), 32'd1);
    send_item(CMD_WRITE, chan_addr(3, SLOT_LOAD), 32'd2);
    for (int i = 0; i < CHANNELS; i++)
      send_item(CMD_WRITE, chan_addr(i, SLOT_CTRL), '1);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '1, '1);
    send_item(CMD_READ, chan_addr(0, SLOT_COUNT), '0);
    send_item(CMD_WRITE, chan_addr(3, SLOT_COUNT), 32'h0000_1234);
    send_item(CMD_WRITE, chan_addr(1, SLOT_FLAG), 32'hFFFF_FFFE);
    send_item(CMD_WRITE, chan_addr(1, SLOT_FLAG), 32'd1);
    send_item(CMD_WRITE, ADDR_MCTRL, '1);                // sets both bits; bit 1 stops all channels
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_READ, ADDR_MCTRL, '0);
    send_item(CMD_READ, ADDR_CHAN_BASE + ADDR_W'(2), '0); // unaligned
    send_item(CMD_WRITE, chan_addr(CHANNELS, SLOT_LOAD), '1);
    send_item(CMD_READ, '1, '0);
    send_item(CMD_NONE, ADDR_MCTRL, '1);
    send_item(CMD_WRITE, ADDR_MCTRL, '0);
  endtask

  initial begin
    int burst;
    int gap;
    bit hold_issued;
    bit mid_drained;
    hold_issued = 1'b0;
    mid_drained = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain_results();
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_issued && items_sent >= RANDOM_ITEMS / 3) begin
        // keep offering while the receiver holds off
        hold_issued = 1'b1;
        hold_requests++;
        repeat (48) send_random_access();
      end else if (!mid_drained && items_sent >= 2 * RANDOM_ITEMS / 3) begin
        mid_drained = 1'b1;
        drain_results();
      end
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      repeat (burst) send_random_access();
      gap = $urandom_range(0, 6);
      if (gap != 0) idle_cycles(gap);
    end
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("** periodic_interrupt_timer_4ch: PASSED **");
    else
      $display("** periodic_interrupt_timer_4ch: FAILED **");
    $finish;
  end

  // receiver: modes of random length, plus one long hold on request
  initial begin
    int mode;
    int left;
    int phase;
    int holds_served;
    mode = 0;
    left = 0;
    phase = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 80);
        end
        left--;
        phase++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (phase % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // outputs are stable between the falling edge and the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      sb.check_result(rdata, irq_lines);
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** periodic_interrupt_timer_4ch: FAILED **");
        $finish;
      end
    end
  end

endmodule
